### rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the thread scheduler: command and status
// codes, datapath operations and the control/status bundles.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int LEVELS_DEF      = 4;

  localparam int CMD_W     = 3;
  localparam int SLOT_W    = 4;
  localparam int LEVEL_W   = 2;
  localparam int QUANTA_W  = 16;
  localparam int CODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [QUANTA_W-1:0] QUANTA_MAX = '1;
  localparam logic [CFG_DAT_W-1:0] BOOST_PERIOD_RST = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_PERIOD = 1'b1;

  localparam logic [CODE_W-1:0] RC_OK    = 2'd0;
  localparam logic [CODE_W-1:0] RC_EMPTY = 2'd1;
  localparam logic [CODE_W-1:0] RC_SLOT  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_DISPATCH  = 3'd1,
    CMD_PREEMPT   = 3'd2,
    CMD_YIELD     = 3'd3,
    CMD_BLOCK     = 3'd4,
    CMD_EXIT      = 3'd5,
    CMD_UNBLOCK   = 3'd6,
    CMD_SET_LEVEL = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUN     = 2'd2,
    ST_BLOCKED = 2'd3
  } slot_st_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ERR_SLOT,
    OP_ERR_NONE,
    OP_CREATE,
    OP_SETLVL,
    OP_RUN_FETCH,
    OP_END_START,
    OP_POP_RDY,
    OP_POP_BLK,
    OP_WALK_START,
    OP_CAPTURE,
    OP_POP_RUN,
    OP_POP_UNBLK,
    OP_WALK_EV,
    OP_WALK_RM,
    OP_END,
    OP_BMERGE,
    OP_BSWEEP,
    OP_BREQ,
    OP_PUSH,
    OP_LINK,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic mode;
    logic slot_bad;
    logic run_busy;
    logic any_ready;
    logic l0_empty;
    logic blk_empty;
    logic walk_last;
    logic boost_hit;
    logic merge_last;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer of the scheduler: decodes each command and steps the datapath
// through list pops, the shortest-service walk, the boost and the requeue.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlfq_pkg::dp_stat_t  stat_i,
  output mlfq_pkg::dp_cmd_t   cmd_o
);
  import mlfq_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_DECODE  = 15'h0002,
    S_WAIT    = 15'h0004,
    S_CAP     = 15'h0008,
    S_POP     = 15'h0010,
    S_WALK_RD = 15'h0020,
    S_WALK_EV = 15'h0040,
    S_WALK_RM = 15'h0080,
    S_END     = 15'h0100,
    S_BMERGE  = 15'h0200,
    S_BSWEEP  = 15'h0400,
    S_BREQ    = 15'h0800,
    S_PUSH    = 15'h1000,
    S_LINK    = 15'h2000,
    S_EMIT    = 15'h4000
  } state_e;

  state_e state_q, state_d;
  op_e    op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_ACCEPT;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_CREATE, CMD_SET_LEVEL: begin
            if (stat_i.slot_bad) begin
              op      = OP_ERR_SLOT;
              state_d = S_EMIT;
            end else if (stat_i.cmd == CMD_CREATE) begin
              op      = OP_CREATE;
              state_d = S_PUSH;
            end else begin
              op      = OP_SETLVL;
              state_d = S_WAIT;
            end
          end
          CMD_DISPATCH: begin
            if (stat_i.run_busy) begin
              op      = OP_RUN_FETCH;
              state_d = S_WAIT;
            end else if (stat_i.mode && stat_i.any_ready) begin
              op      = OP_POP_RDY;
              state_d = S_WAIT;
            end else if (!stat_i.mode && !stat_i.l0_empty) begin
              op      = OP_WALK_START;
              state_d = S_WALK_RD;
            end else begin
              op      = OP_ERR_NONE;
              state_d = S_EMIT;
            end
          end
          CMD_UNBLOCK: begin
            if (stat_i.blk_empty) begin
              op      = OP_ERR_NONE;
              state_d = S_EMIT;
            end else begin
              op      = OP_POP_BLK;
              state_d = S_WAIT;
            end
          end
          default: begin
            if (stat_i.run_busy) begin
              op      = OP_END_START;
              state_d = S_WAIT;
            end else begin
              op      = OP_ERR_NONE;
              state_d = S_EMIT;
            end
          end
        endcase
      end
      S_WAIT: begin
        unique case (stat_i.cmd)
          CMD_DISPATCH:  state_d = stat_i.run_busy ? S_CAP : S_POP;
          CMD_SET_LEVEL: state_d = S_CAP;
          CMD_UNBLOCK:   state_d = S_POP;
          default:       state_d = S_END;
        endcase
      end
      S_CAP: begin
        op      = OP_CAPTURE;
        state_d = S_EMIT;
      end
      S_POP: begin
        if (stat_i.cmd == CMD_DISPATCH) begin
          op      = OP_POP_RUN;
          state_d = S_EMIT;
        end else begin
          op      = OP_POP_UNBLK;
          state_d = S_PUSH;
        end
      end
      S_WALK_RD: state_d = S_WALK_EV;
      S_WALK_EV: begin
        op      = OP_WALK_EV;
        state_d = stat_i.walk_last ? S_WALK_RM : S_WALK_RD;
      end
      S_WALK_RM: begin
        op      = OP_WALK_RM;
        state_d = S_EMIT;
      end
      S_END: begin
        op = OP_END;
        if (stat_i.boost_hit) begin
          state_d = S_BMERGE;
        end else if (stat_i.cmd == CMD_EXIT) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_BMERGE: begin
        op = OP_BMERGE;
        if (stat_i.merge_last) begin
          state_d = S_BSWEEP;
        end
      end
      S_BSWEEP: begin
        op = OP_BSWEEP;
        if (stat_i.sweep_last) begin
          state_d = S_BREQ;
        end
      end
      S_BREQ: begin
        op      = OP_BREQ;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        op      = OP_PUSH;
        state_d = S_LINK;
      end
      S_LINK: begin
        op      = OP_LINK;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          op      = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op;

endmodule

### rtl/mlfq_datapath.sv
// ----------------------------------------------------------------------------
// mlfq_datapath
// Slot table, list heads and tails, running slot, tick counter, working
// registers and the result register of the thread scheduler.
// ----------------------------------------------------------------------------
module mlfq_datapath #(
  parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
  parameter int LEVELS      = mlfq_pkg::LEVELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mlfq_pkg::dp_cmd_t                   cmd_i,
  output mlfq_pkg::dp_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mlfq_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic [mlfq_pkg::CMD_W-1:0]          command_i,
  input  logic [mlfq_pkg::SLOT_W-1:0]         thread_slot_i,
  input  logic [mlfq_pkg::LEVEL_W-1:0]        new_level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mlfq_pkg::SLOT_W-1:0]         chosen_slot_o,
  output logic                                chosen_valid_o,
  output logic [mlfq_pkg::LEVEL_W-1:0]        chosen_level_o,
  output logic [mlfq_pkg::QUANTA_W-1:0]       chosen_quanta_o,
  output logic                                boost_done_o,
  output logic [mlfq_pkg::CODE_W-1:0]         status_code_o
);
  import mlfq_pkg::*;

  localparam int SW  = $clog2(MAX_THREADS);
  localparam int PW  = $clog2(MAX_THREADS + 1);
  localparam int LVW = $clog2(LEVELS);
  localparam int LIW = $clog2(LEVELS + 1);
  localparam logic [PW-1:0]  NIL      = PW'(MAX_THREADS);
  localparam logic [PW-1:0]  LAST_SLT = PW'(MAX_THREADS - 1);
  localparam logic [LVW-1:0] TOP_LVL  = LVW'(LEVELS - 1);
  localparam logic [LIW-1:0] BLK_LIST = LIW'(LEVELS);
  localparam logic [LIW-1:0] LAST_LST = LIW'(LEVELS - 1);

  // Control state (reset)
  logic                 mode_q, mode_d;
  logic [CFG_DAT_W-1:0] period_q, period_d;
  logic [QUANTA_W-1:0]  tick_q, tick_d;
  logic [PW-1:0]        running_q, running_d;
  logic [PW-1:0]        head_q [LEVELS+1];
  logic [PW-1:0]        head_d [LEVELS+1];
  logic [PW-1:0]        tail_q [LEVELS+1];
  logic [PW-1:0]        tail_d [LEVELS+1];
  slot_st_e             st_q [MAX_THREADS];
  logic                 out_valid_q, out_valid_d;

  // Working and result registers
  cmd_e                 cmd_q, cmd_d;
  logic [SLOT_W-1:0]    slot_in_q, slot_in_d;
  logic [LEVEL_W-1:0]   lvl_in_q, lvl_in_d;
  logic [PW-1:0]        cur_q, cur_d;
  logic [PW-1:0]        prev_q, prev_d;
  logic [PW-1:0]        best_q, best_d;
  logic [PW-1:0]        bprev_q, bprev_d;
  logic [PW-1:0]        bnext_q, bnext_d;
  logic [QUANTA_W-1:0]  bqnt_q, bqnt_d;
  logic [LVW-1:0]       blvl_q, blvl_d;
  logic [PW-1:0]        n_q, n_d;
  logic [PW-1:0]        sv_q, sv_d;
  logic [PW-1:0]        ptail_q, ptail_d;
  logic                 link_q, link_d;
  logic [LIW-1:0]       list_q, list_d;
  logic [LVW-1:0]       lvl_q, lvl_d;
  logic [QUANTA_W-1:0]  qnt_q, qnt_d;
  logic                 err_q, err_d;
  logic [CODE_W-1:0]    code_q, code_d;
  logic                 boost_q, boost_d;
  logic [SLOT_W-1:0]    o_slot_q, o_slot_d;
  logic                 o_valid_q, o_valid_d;
  logic [LEVEL_W-1:0]   o_lvl_q, o_lvl_d;
  logic [QUANTA_W-1:0]  o_qnt_q, o_qnt_d;
  logic                 o_boost_q, o_boost_d;
  logic [CODE_W-1:0]    o_code_q, o_code_d;

  // Slot table memories and the status write port
  logic                 lvl_we, qnt_we, nxt_we, st_we;
  logic [LVW-1:0]       lvl_wdata, lvl_rd;
  logic [QUANTA_W-1:0]  qnt_wdata, qnt_rd;
  logic [PW-1:0]        nxt_wdata, nxt_rd;
  logic [SW-1:0]        nxt_waddr, st_waddr;
  slot_st_e             st_wdata;

  logic [SW-1:0]        cur_idx;
  slot_st_e             st_cur;
  logic                 in_range;
  logic                 rdy_any;
  logic [LIW-1:0]       rdy_idx;
  logic [PW-1:0]        rdy_head;
  logic [QUANTA_W-1:0]  tick_inc;
  logic [QUANTA_W-1:0]  qnt_new;
  logic [LVW-1:0]       lvl_new;
  logic [LVW-1:0]       lvl_set;
  logic                 boost_hit;

  assign cur_idx  = cur_q[SW-1:0];
  assign st_cur   = st_q[cur_idx];
  assign in_range = (32'(slot_in_q) < MAX_THREADS);
  assign tick_inc = tick_q + QUANTA_W'(1);
  assign qnt_new  = (qnt_rd != QUANTA_MAX) ? qnt_rd + QUANTA_W'(1) : qnt_rd;
  assign boost_hit = (cmd_q == CMD_PREEMPT) && mode_q && (tick_inc >= period_q);

  always_comb begin
    if (mode_q && (cmd_q == CMD_PREEMPT) && (lvl_rd < TOP_LVL)) begin
      lvl_new = lvl_rd + LVW'(1);
    end else begin
      lvl_new = lvl_rd;
    end
    if (32'(lvl_in_q) > LEVELS - 1) begin
      lvl_set = TOP_LVL;
    end else begin
      lvl_set = LVW'(lvl_in_q);
    end
  end

  // Highest-priority (lowest-numbered) non-empty ready level.
  always_comb begin
    rdy_any  = 1'b0;
    rdy_idx  = '0;
    rdy_head = NIL;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (head_q[i] != NIL) begin
        rdy_any  = 1'b1;
        rdy_idx  = LIW'(i);
        rdy_head = head_q[i];
      end
    end
  end

  always_comb begin
    mode_d      = mode_q;
    period_d    = period_q;
    tick_d      = tick_q;
    running_d   = running_q;
    head_d      = head_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    slot_in_d   = slot_in_q;
    lvl_in_d    = lvl_in_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    best_d      = best_q;
    bprev_d     = bprev_q;
    bnext_d     = bnext_q;
    bqnt_d      = bqnt_q;
    blvl_d      = blvl_q;
    n_d         = n_q;
    sv_d        = sv_q;
    ptail_d     = ptail_q;
    link_d      = link_q;
    list_d      = list_q;
    lvl_d       = lvl_q;
    qnt_d       = qnt_q;
    err_d       = err_q;
    code_d      = code_q;
    boost_d     = boost_q;
    o_slot_d    = o_slot_q;
    o_valid_d   = o_valid_q;
    o_lvl_d     = o_lvl_q;
    o_qnt_d     = o_qnt_q;
    o_boost_d   = o_boost_q;
    o_code_d    = o_code_q;
    lvl_we      = 1'b0;
    lvl_wdata   = '0;
    qnt_we      = 1'b0;
    qnt_wdata   = '0;
    nxt_we      = 1'b0;
    nxt_waddr   = cur_idx;
    nxt_wdata   = NIL;
    st_we       = 1'b0;
    st_waddr    = cur_idx;
    st_wdata    = ST_FREE;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY_MODE:  mode_d   = cfg_data_i[0];
        REG_BOOST_PERIOD: period_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (cmd_i.op)
      OP_ACCEPT: begin
        cmd_d     = cmd_e'(command_i);
        slot_in_d = thread_slot_i;
        lvl_in_d  = new_level_i;
        cur_d     = PW'(thread_slot_i);
        err_d     = 1'b0;
        code_d    = RC_OK;
        boost_d   = 1'b0;
      end
      OP_ERR_SLOT: begin
        err_d  = 1'b1;
        code_d = RC_SLOT;
      end
      OP_ERR_NONE: begin
        err_d  = 1'b1;
        code_d = RC_EMPTY;
      end
      OP_CREATE: begin
        lvl_we   = 1'b1;
        qnt_we   = 1'b1;
        st_we    = 1'b1;
        st_wdata = ST_READY;
        lvl_d    = '0;
        qnt_d    = '0;
        list_d   = '0;
      end
      OP_SETLVL: begin
        lvl_we    = 1'b1;
        lvl_wdata = lvl_set;
        lvl_d     = lvl_set;
      end
      OP_RUN_FETCH: begin
        cur_d  = running_q;
        code_d = RC_SLOT;
      end
      OP_END_START: begin
        cur_d     = running_q;
        running_d = NIL;
      end
      OP_POP_RDY: begin
        cur_d  = rdy_head;
        list_d = rdy_idx;
      end
      OP_POP_BLK: begin
        cur_d  = head_q[LEVELS];
        list_d = BLK_LIST;
      end
      OP_WALK_START: begin
        cur_d  = head_q[0];
        prev_d = NIL;
        n_d    = '0;
      end
      OP_CAPTURE: begin
        lvl_d = lvl_rd;
        qnt_d = qnt_rd;
      end
      OP_POP_RUN, OP_POP_UNBLK: begin
        head_d[list_q] = nxt_rd;
        if (nxt_rd == NIL) begin
          tail_d[list_q] = NIL;
        end
        qnt_d = qnt_rd;
        st_we = 1'b1;
        if (cmd_i.op == OP_POP_RUN) begin
          lvl_d     = lvl_rd;
          st_wdata  = ST_RUN;
          running_d = cur_q;
        end else begin
          lvl_d    = '0;
          lvl_we   = 1'b1;
          st_wdata = ST_READY;
          list_d   = '0;
        end
      end
      OP_WALK_EV: begin
        // Strict compare keeps the earliest thread on a tie.
        if ((n_q == '0) || (qnt_rd < bqnt_q)) begin
          best_d  = cur_q;
          bqnt_d  = qnt_rd;
          blvl_d  = lvl_rd;
          bprev_d = prev_q;
          bnext_d = nxt_rd;
        end
        prev_d = cur_q;
        cur_d  = nxt_rd;
        n_d    = n_q + PW'(1);
      end
      OP_WALK_RM: begin
        if (bprev_q == NIL) begin
          head_d[0] = bnext_q;
          if (bnext_q == NIL) begin
            tail_d[0] = NIL;
          end
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = bprev_q[SW-1:0];
          nxt_wdata = bnext_q;
          if (tail_q[0] == best_q) begin
            tail_d[0] = bprev_q;
          end
        end
        running_d = best_q;
        st_we     = 1'b1;
        st_waddr  = best_q[SW-1:0];
        st_wdata  = ST_RUN;
        cur_d     = best_q;
        lvl_d     = blvl_q;
        qnt_d     = bqnt_q;
      end
      OP_END: begin
        qnt_we    = 1'b1;
        qnt_wdata = qnt_new;
        qnt_d     = qnt_new;
        lvl_we    = 1'b1;
        lvl_wdata = lvl_new;
        lvl_d     = lvl_new;
        sv_d      = cur_q;
        if ((cmd_q == CMD_PREEMPT) && mode_q) begin
          tick_d = boost_hit ? '0 : tick_inc;
        end
        if (boost_hit) begin
          boost_d = 1'b1;
          list_d  = LIW'(1);
        end else if (cmd_q == CMD_BLOCK) begin
          st_we    = 1'b1;
          st_wdata = ST_BLOCKED;
          list_d   = BLK_LIST;
        end else if (cmd_q == CMD_EXIT) begin
          st_we    = 1'b1;
          st_wdata = ST_FREE;
        end else begin
          st_we    = 1'b1;
          st_wdata = ST_READY;
          list_d   = mode_q ? LIW'(lvl_new) : '0;
        end
      end
      OP_BMERGE: begin
        // Append the whole list of this level to level 0.
        if (head_q[list_q] != NIL) begin
          if (head_q[0] == NIL) begin
            head_d[0] = head_q[list_q];
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_q[0][SW-1:0];
            nxt_wdata = head_q[list_q];
          end
          tail_d[0]      = tail_q[list_q];
          head_d[list_q] = NIL;
          tail_d[list_q] = NIL;
        end
        list_d = list_q + LIW'(1);
        if (list_q == LAST_LST) begin
          cur_d = '0;
        end
      end
      OP_BSWEEP: begin
        if (st_cur != ST_FREE) begin
          lvl_we = 1'b1;
        end
        cur_d = cur_q + PW'(1);
      end
      OP_BREQ: begin
        cur_d    = sv_q;
        st_we    = 1'b1;
        st_waddr = sv_q[SW-1:0];
        st_wdata = ST_READY;
        lvl_d    = '0;
        list_d   = '0;
      end
      OP_PUSH: begin
        nxt_we = 1'b1;
        if (head_q[list_q] == NIL) begin
          head_d[list_q] = cur_q;
          link_d         = 1'b0;
        end else begin
          link_d  = 1'b1;
          ptail_d = tail_q[list_q];
        end
        tail_d[list_q] = cur_q;
      end
      OP_LINK: begin
        if (link_q) begin
          nxt_we    = 1'b1;
          nxt_waddr = ptail_q[SW-1:0];
          nxt_wdata = cur_q;
        end
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        o_code_d    = code_q;
        if (err_q) begin
          o_slot_d  = (code_q == RC_SLOT) ? slot_in_q : '0;
          o_valid_d = 1'b0;
          o_lvl_d   = '0;
          o_qnt_d   = '0;
          o_boost_d = 1'b0;
        end else begin
          o_slot_d  = SLOT_W'(cur_q);
          o_valid_d = 1'b1;
          o_lvl_d   = LEVEL_W'(lvl_q);
          o_qnt_d   = qnt_q;
          o_boost_d = boost_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      period_q    <= BOOST_PERIOD_RST;
      tick_q      <= '0;
      running_q   <= NIL;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= LEVELS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
      for (int i = 0; i < MAX_THREADS; i++) begin
        st_q[i] <= ST_FREE;
      end
    end else begin
      mode_q      <= mode_d;
      period_q    <= period_d;
      tick_q      <= tick_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      if (st_we) begin
        st_q[st_waddr] <= st_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    slot_in_q <= slot_in_d;
    lvl_in_q  <= lvl_in_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    best_q    <= best_d;
    bprev_q   <= bprev_d;
    bnext_q   <= bnext_d;
    bqnt_q    <= bqnt_d;
    blvl_q    <= blvl_d;
    n_q       <= n_d;
    sv_q      <= sv_d;
    ptail_q   <= ptail_d;
    link_q    <= link_d;
    list_q    <= list_d;
    lvl_q     <= lvl_d;
    qnt_q     <= qnt_d;
    err_q     <= err_d;
    code_q    <= code_d;
    boost_q   <= boost_d;
    o_slot_q  <= o_slot_d;
    o_valid_q <= o_valid_d;
    o_lvl_q   <= o_lvl_d;
    o_qnt_q   <= o_qnt_d;
    o_boost_q <= o_boost_d;
    o_code_q  <= o_code_d;
  end

  mlfq_ram #(.WIDTH(LVW), .DEPTH(MAX_THREADS)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (cur_idx),
    .wdata_i (lvl_wdata),
    .raddr_i (cur_idx),
    .rdata_o (lvl_rd)
  );

  mlfq_ram #(.WIDTH(QUANTA_W), .DEPTH(MAX_THREADS)) u_quanta_ram (
    .clk_i   (clk_i),
    .we_i    (qnt_we),
    .waddr_i (cur_idx),
    .wdata_i (qnt_wdata),
    .raddr_i (cur_idx),
    .rdata_o (qnt_rd)
  );

  mlfq_ram #(.WIDTH(PW), .DEPTH(MAX_THREADS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (cur_idx),
    .rdata_o (nxt_rd)
  );

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.mode       = mode_q;
    stat_o.slot_bad   = (cmd_q == CMD_CREATE) ? (!in_range || (st_cur != ST_FREE))
                                              : (!in_range || (st_cur == ST_FREE));
    stat_o.run_busy   = (running_q != NIL);
    stat_o.any_ready  = rdy_any;
    stat_o.l0_empty   = (head_q[0] == NIL);
    stat_o.blk_empty  = (head_q[LEVELS] == NIL);
    stat_o.walk_last  = (nxt_rd == NIL) || (n_q == LAST_SLT);
    stat_o.boost_hit  = boost_hit;
    stat_o.merge_last = (list_q == LAST_LST);
    stat_o.sweep_last = (cur_q == LAST_SLT);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_slot_o   = o_slot_q;
  assign chosen_valid_o  = o_valid_q;
  assign chosen_level_o  = o_lvl_q;
  assign chosen_quanta_o = o_qnt_q;
  assign boost_done_o    = o_boost_q;
  assign status_code_o   = o_code_q;

endmodule

### rtl/mlfq_thread_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_thread_scheduler
// Multilevel feedback queue thread scheduler with periodic priority boost
// and a shortest-service dispatch mode.
// ----------------------------------------------------------------------------
// One command is handled at a time and gives exactly one result. A
// shortest-service dispatch walks level 0 through the slot RAMs, reading
// and then evaluating each queued thread in turn. A timer tick that
// triggers a boost adds a splice of the ready lists onto level 0, a sweep
// that resets every live level, one slot per cycle through the single
// write port of the level RAM, and a requeue of the running thread. No
// clearing pass is needed after reset. A finished result is held in the
// output register while the next command is accepted.
module mlfq_thread_scheduler #(
  parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
  parameter int LEVELS      = mlfq_pkg::LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mlfq_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mlfq_pkg::CMD_W-1:0]     command_i,
  input  logic [mlfq_pkg::SLOT_W-1:0]    thread_slot_i,
  input  logic [mlfq_pkg::LEVEL_W-1:0]   new_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mlfq_pkg::SLOT_W-1:0]    chosen_slot_o,
  output logic                           chosen_valid_o,
  output logic [mlfq_pkg::LEVEL_W-1:0]   chosen_level_o,
  output logic [mlfq_pkg::QUANTA_W-1:0]  chosen_quanta_o,
  output logic                           boost_done_o,
  output logic [mlfq_pkg::CODE_W-1:0]    status_code_o
);
  import mlfq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mlfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  mlfq_datapath #(
    .MAX_THREADS (MAX_THREADS),
    .LEVELS      (LEVELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .thread_slot_i   (thread_slot_i),
    .new_level_i     (new_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .chosen_slot_o   (chosen_slot_o),
    .chosen_valid_o  (chosen_valid_o),
    .chosen_level_o  (chosen_level_o),
    .chosen_quanta_o (chosen_quanta_o),
    .boost_done_o    (boost_done_o),
    .status_code_o   (status_code_o)
  );

endmodule
